>>> hw/rtl/gff_pkg.sv
// Shared types and constants for the grid flood fill block.
// No dependencies; imported by gff_stack_cell, gff_stack and grid_flood_fill_core.
`default_nettype none

package gff_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 16;
    localparam int CELL_BITS_DEF = 8;

    localparam int OP_W    = 2;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 8;
    localparam int CNT_W   = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic CFG_FILL_COLOUR   = 1'b0;
    localparam logic CFG_TARGET_COLOUR = 1'b1;

    localparam logic [VAL_W-1:0] FILL_COLOUR_RST   = 8'd5;
    localparam logic [VAL_W-1:0] TARGET_COLOUR_RST = 8'd0;

    localparam logic [CNT_W-1:0] COUNT_MAX = 9'h1FF;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/gff_stack_cell.sv
// One entry of the shift stack: takes the entry above on push, the one below on pop.
// Depends on gff_pkg for the stack control struct.
`default_nettype none

module gff_stack_cell #(
    parameter int WIDTH = 8
) (
    input  wire                  i_clk,
    input  gff_pkg::t_stack_ctl  i_ctl,
    input  wire  [WIDTH-1:0]     i_from_up,
    input  wire  [WIDTH-1:0]     i_from_down,
    output logic [WIDTH-1:0]     o_entry
);

    logic [WIDTH-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> hw/rtl/gff_stack.sv
// LIFO of pending cell positions built as a chain of gff_stack_cell, top at cell 0.
// Depends on gff_pkg and gff_stack_cell.
`default_nettype none

module gff_stack #(
    parameter int DEPTH = gff_pkg::GRID_ROWS_DEF * gff_pkg::GRID_COLS_DEF,
    parameter int WIDTH = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  gff_pkg::t_stack_ctl  i_ctl,
    input  wire  [WIDTH-1:0]     i_push_data,
    output logic [WIDTH-1:0]     o_top,
    output logic                 o_empty
);

    localparam int DepthW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  w_entry [DEPTH];
    logic [DepthW-1:0] r_depth;
    logic [DepthW-1:0] n_depth;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WIDTH-1:0] w_up;
        logic [WIDTH-1:0] w_down;

        if (k == 0) begin : g_top
            assign w_up = i_push_data;
        end else begin : g_mid
            assign w_up = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_bot
            assign w_down = w_entry[k];
        end else begin : g_inner
            assign w_down = w_entry[k+1];
        end

        gff_stack_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_entry     (w_entry[k])
        );
    end

    always_comb begin
        n_depth = r_depth;
        priority if (i_ctl.push) begin
            n_depth = r_depth + 1'b1;
        end else if (i_ctl.pop) begin
            n_depth = r_depth - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    assign o_top   = w_entry[0];
    assign o_empty = (r_depth == '0);

endmodule

`default_nettype wire

>>> hw/rtl/grid_flood_fill_core.sv
// Grid flood fill: a write's result is registered as the request is taken, a read's after S_READ;
// a fill runs S_POP and S_SCAN per popped cell, with one grid memory read per neighbour.
// One request in flight at a time; the next is taken once its result register is free.
// Reset (synchronous, active low) clears control, stack depth and colours (fill 5, target 0).
// Grid contents are undefined until written; there is no clearing pass.
// Depends on gff_pkg and gff_stack.
`default_nettype none

module grid_flood_fill_core #(
    parameter int GRID_ROWS = gff_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = gff_pkg::GRID_COLS_DEF,
    parameter int CELL_BITS = gff_pkg::CELL_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,

    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [gff_pkg::OP_W-1:0]      i_op,
    input  wire  [gff_pkg::POS_W-1:0]     i_row,
    input  wire  [gff_pkg::POS_W-1:0]     i_col,
    input  wire  [gff_pkg::VAL_W-1:0]     i_cell_value,

    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [gff_pkg::VAL_W-1:0]     o_read_value,
    output logic [gff_pkg::CNT_W-1:0]     o_painted_count,
    output logic                          o_status,

    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [gff_pkg::APB_AW-1:0]    paddr,
    input  wire  [gff_pkg::APB_DW-1:0]    pwdata,
    output logic [gff_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import gff_pkg::*;

    localparam int NumCells = GRID_ROWS * GRID_COLS;
    localparam int RowW     = $clog2(GRID_ROWS);
    localparam int ColW     = $clog2(GRID_COLS);
    localparam int AddrW    = $clog2(NumCells);
    localparam int PosW     = RowW + ColW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_POP  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        DIR_DOWN  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_END   = 3'd4
    } t_dir;

    t_state r_state, n_state;
    t_dir   r_dir,   n_dir;

    logic [RowW-1:0]      r_cur_r, n_cur_r;
    logic [ColW-1:0]      r_cur_c, n_cur_c;
    logic                 r_chk_valid, n_chk_valid;
    logic [RowW-1:0]      r_chk_r, n_chk_r;
    logic [ColW-1:0]      r_chk_c, n_chk_c;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [VAL_W-1:0]     r_fill, r_target;
    logic                 r_out_valid, n_out_valid;
    logic [VAL_W-1:0]     r_out_read, n_out_read;
    logic [CNT_W-1:0]     r_out_count, n_out_count;
    logic                 r_out_status, n_out_status;

    logic [CELL_BITS-1:0] r_mem [NumCells];
    logic [CELL_BITS-1:0] r_rd_data;

    logic                 w_we;
    logic [AddrW-1:0]     w_waddr;
    logic [CELL_BITS-1:0] w_wdata;
    logic [AddrW-1:0]     w_raddr;

    t_stack_ctl           w_stack_ctl;
    logic [PosW-1:0]      w_push_pos;
    logic [PosW-1:0]      w_top;
    logic                 w_empty;

    logic [CELL_BITS-1:0] w_fc, w_tc;
    logic                 w_in_acc;
    logic                 w_in_inside;
    logic [RowW-1:0]      w_in_r;
    logic [ColW-1:0]      w_in_c;
    logic [AddrW-1:0]     w_in_addr;

    logic [RowW-1:0]      w_nb_r;
    logic [ColW-1:0]      w_nb_c;
    logic                 w_nb_ok;
    logic [AddrW-1:0]     w_nb_addr;
    logic [AddrW-1:0]     w_chk_addr;

    logic                 w_cfg_wr;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= FILL_COLOUR_RST;
            r_target <= TARGET_COLOUR_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                CFG_FILL_COLOUR:   r_fill   <= pwdata[VAL_W-1:0];
                CFG_TARGET_COLOUR: r_target <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_FILL_COLOUR:   prdata = APB_DW'(r_fill);
            CFG_TARGET_COLOUR: prdata = APB_DW'(r_target);
            default:           prdata = '0;
        endcase
    end

    assign w_fc = CELL_BITS'(r_fill);
    assign w_tc = CELL_BITS'(r_target);

    // Request decode
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_in_inside = (32'(i_row) < GRID_ROWS) && (32'(i_col) < GRID_COLS);
    assign w_in_r      = RowW'(i_row);
    assign w_in_c      = ColW'(i_col);
    assign w_in_addr   = AddrW'(w_in_r) * AddrW'(GRID_COLS) + AddrW'(w_in_c);

    // Neighbour of the popped cell for the current direction
    always_comb begin
        w_nb_r  = r_cur_r;
        w_nb_c  = r_cur_c;
        w_nb_ok = 1'b0;
        case (r_dir)
            DIR_DOWN: begin
                w_nb_r  = r_cur_r + 1'b1;
                w_nb_ok = (r_cur_r != RowW'(GRID_ROWS - 1));
            end
            DIR_UP: begin
                w_nb_r  = r_cur_r - 1'b1;
                w_nb_ok = (r_cur_r != '0);
            end
            DIR_RIGHT: begin
                w_nb_c  = r_cur_c + 1'b1;
                w_nb_ok = (r_cur_c != ColW'(GRID_COLS - 1));
            end
            DIR_LEFT: begin
                w_nb_c  = r_cur_c - 1'b1;
                w_nb_ok = (r_cur_c != '0);
            end
            default: w_nb_ok = 1'b0;
        endcase
    end

    assign w_nb_addr  = AddrW'(w_nb_r) * AddrW'(GRID_COLS) + AddrW'(w_nb_c);
    assign w_chk_addr = AddrW'(r_chk_r) * AddrW'(GRID_COLS) + AddrW'(r_chk_c);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_dir        = r_dir;
        n_cur_r      = r_cur_r;
        n_cur_c      = r_cur_c;
        n_chk_valid  = 1'b0;
        n_chk_r      = r_chk_r;
        n_chk_c      = r_chk_c;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_read   = r_out_read;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;

        w_we             = 1'b0;
        w_waddr          = w_in_addr;
        w_wdata          = CELL_BITS'(i_cell_value);
        w_raddr          = w_in_addr;
        w_stack_ctl.push = 1'b0;
        w_stack_ctl.pop  = 1'b0;
        w_push_pos       = {w_in_r, w_in_c};

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_read   = '0;
                    n_out_count  = '0;
                    n_out_status = 1'b0;
                    case (i_op)
                        OP_WRITE: begin
                            w_we = w_in_inside;
                        end
                        OP_READ: begin
                            if (w_in_inside) begin
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        OP_FILL: begin
                            priority if (w_fc == w_tc) begin
                                n_out_status = 1'b1;
                            end else if (w_in_inside) begin
                                n_out_valid      = 1'b0;
                                w_we             = 1'b1;
                                w_wdata          = w_fc;
                                w_stack_ctl.push = 1'b1;
                                n_count          = CNT_W'(1);
                                n_state          = S_POP;
                            end else begin
                                n_out_status = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_read  = VAL_W'(r_rd_data);
                n_state     = S_IDLE;
            end
            S_POP: begin
                if (w_empty) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_state     = S_IDLE;
                end else begin
                    w_stack_ctl.pop = 1'b1;
                    n_cur_r         = w_top[PosW-1:ColW];
                    n_cur_c         = w_top[ColW-1:0];
                    n_dir           = DIR_DOWN;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // paint and push the neighbour read in the previous cycle
                if (r_chk_valid && (r_rd_data == w_tc)) begin
                    w_we             = 1'b1;
                    w_waddr          = w_chk_addr;
                    w_wdata          = w_fc;
                    w_stack_ctl.push = 1'b1;
                    w_push_pos       = {r_chk_r, r_chk_c};
                    n_count          = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
                end
                w_raddr = w_nb_addr;
                if (r_dir == DIR_END) begin
                    n_state = S_POP;
                end else begin
                    n_chk_valid = w_nb_ok;
                    n_chk_r     = w_nb_r;
                    n_chk_c     = w_nb_c;
                    n_dir       = t_dir'(r_dir + 3'd1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk_valid <= n_chk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir        <= n_dir;
        r_cur_r      <= n_cur_r;
        r_cur_c      <= n_cur_c;
        r_chk_r      <= n_chk_r;
        r_chk_c      <= n_chk_c;
        r_count      <= n_count;
        r_out_read   <= n_out_read;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    gff_stack #(
        .DEPTH (NumCells),
        .WIDTH (PosW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_stack_ctl),
        .i_push_data (w_push_pos),
        .o_top       (w_top),
        .o_empty     (w_empty)
    );

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_out_read;
    assign o_painted_count = r_out_count;
    assign o_status        = r_out_status;

endmodule

`default_nettype wire

>>> sim/grid_flood_fill_core_test.sv
// Self-checking testbench for grid_flood_fill_core: cell writes, reads, flood fills, colour registers.
// Uses its own grid predictor, paced request traffic, random result back-pressure and an APB port.
// Depends on gff_pkg and the grid_flood_fill_core RTL only.
`timescale 1ns / 100ps

module grid_flood_fill_core_test;

    import gff_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_CELLS  = GRID_ROWS_DEF * GRID_COLS_DEF;
    localparam int LAT_CYCLES = 16;
    localparam int QUIET_LIMIT = 12000;
    localparam int ROUND_ITEMS = 48;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [CNT_W-1:0] painted_count;
        logic             status;
    } t_grid_result;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    logic [OP_W-1:0]  req_op;
    logic [POS_W-1:0] req_row;
    logic [POS_W-1:0] req_col;
    logic [VAL_W-1:0] req_value;
    logic out_valid;
    logic out_ready;
    logic [VAL_W-1:0] rsp_read_value;
    logic [CNT_W-1:0] rsp_painted_count;
    logic             rsp_status;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    logic [VAL_W-1:0] grid_model [NUM_CELLS];
    logic [VAL_W-1:0] model_fill;
    logic [VAL_W-1:0] model_target;
    t_grid_result     pending_results[$];

    int  error_count;
    int  quiet_cycles;
    int  burst_left;
    bit  gaps_on;
    int  n_writes;
    int  n_reads;
    int  n_fills;
    int  n_refused;
    int  n_unused;
    int  n_settings;
    int  max_painted;

    logic [15:0] stall_pattern;
    logic [7:0]  stall_tick;

    grid_flood_fill_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (req_op),
        .i_row          (req_row),
        .i_col          (req_col),
        .i_cell_value   (req_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_read_value   (rsp_read_value),
        .o_painted_count(rsp_painted_count),
        .o_status       (rsp_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int flood_from(int seed);
        int stack [NUM_CELLS];
        int depth;
        int count;
        int idx;
        int r;
        int c;
        int nr;
        int nc;
        int nidx;
        int dr [4];
        int dc [4];
        dr = '{1, -1, 0, 0};
        dc = '{0, 0, 1, -1};
        grid_model[seed] = model_fill;
        count = 1;
        depth = 0;
        stack[depth] = seed;
        depth++;
        while (depth > 0) begin
            depth--;
            idx = stack[depth];
            r = idx / GRID_COLS_DEF;
            c = idx % GRID_COLS_DEF;
            for (int k = 0; k < 4; k++) begin
                nr = r + dr[k];
                nc = c + dc[k];
                if (nr >= 0 && nc >= 0 && nr < GRID_ROWS_DEF && nc < GRID_COLS_DEF) begin
                    nidx = nr * GRID_COLS_DEF + nc;
                    if (grid_model[nidx] == model_target) begin
                        grid_model[nidx] = model_fill;
                        count++;
                        if (depth < NUM_CELLS) begin
                            stack[depth] = nidx;
                            depth++;
                        end
                    end
                end
            end
        end
        return count;
    endfunction

    function automatic t_grid_result predict_grid_op(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                                                     logic [POS_W-1:0] col, logic [VAL_W-1:0] value);
        t_grid_result res;
        int idx;
        int painted;
        res = '0;
        idx = int'(row) * GRID_COLS_DEF + int'(col);
        case (op)
            OP_WRITE: begin
                grid_model[idx] = value;
                n_writes++;
            end
            OP_READ: begin
                res.read_value = grid_model[idx];
                n_reads++;
            end
            OP_FILL: begin
                n_fills++;
                if (model_fill == model_target) begin
                    res.status = 1'b1;
                    n_refused++;
                end else begin
                    painted = flood_from(idx);
                    if (painted > int'(COUNT_MAX)) painted = int'(COUNT_MAX);
                    res.painted_count = CNT_W'(painted);
                    if (painted > max_painted) max_painted = painted;
                end
            end
            default: n_unused++;
        endcase
        return res;
    endfunction

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                                logic [POS_W-1:0] col, logic [VAL_W-1:0] value);
        t_grid_result want;
        if (burst_left == 0) begin
            if (gaps_on) idle_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        in_valid  <= 1'b1;
        req_op    <= op;
        req_row   <= row;
        req_col   <= col;
        req_value <= value;
        do @(posedge i_clk); while (!in_ready);
        want = predict_grid_op(op, row, col, value);
        pending_results.insert(pending_results.size(), want);
    endtask

    task automatic wait_all_results;
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LAT_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(logic write, logic idx, logic [VAL_W-1:0] value,
                              output logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(logic idx, logic [VAL_W-1:0] want);
        logic [APB_DW-1:0] data;
        apb_access(1'b0, idx, '0, data);
        if (data[VAL_W-1:0] !== want) begin
            $error("register %0d: expected %0d, got %0d", idx, want, data[VAL_W-1:0]);
            error_count++;
        end
    endtask

    task automatic set_colours(logic [VAL_W-1:0] fill, logic [VAL_W-1:0] target);
        logic [APB_DW-1:0] data;
        wait_all_results();
        apb_access(1'b1, CFG_FILL_COLOUR, fill, data);
        model_fill = fill;
        apb_access(1'b1, CFG_TARGET_COLOUR, target, data);
        model_target = target;
        check_register(CFG_FILL_COLOUR, fill);
        check_register(CFG_TARGET_COLOUR, target);
        n_settings++;
    endtask

    function automatic logic [VAL_W-1:0] pick_cell_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return model_target;
        if (sel < 7) return model_fill;
        if (sel == 7) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return VAL_W'($urandom);
    endfunction

    task automatic send_random_step(output int sent);
        int sel;
        int len;
        int r0;
        int c0;
        int rr;
        int cc;
        bit horiz;
        sent = 0;
        if ($urandom_range(0, 4) == 0) begin
            len   = $urandom_range(2, 8);
            horiz = $urandom_range(0, 1);
            r0    = $urandom_range(0, 15);
            c0    = $urandom_range(0, 15);
            for (int i = 0; i < len; i++) begin
                rr = horiz ? r0 : r0 + i;
                cc = horiz ? c0 + i : c0;
                if (rr > 15 || cc > 15) break;
                send_request(OP_WRITE, POS_W'(rr), POS_W'(cc), model_target);
                sent++;
            end
            send_request(OP_FILL, POS_W'(r0), POS_W'(c0), VAL_W'($urandom));
            sent++;
        end else begin
            sel = $urandom_range(0, 19);
            if (sel < 10)
                send_request(OP_WRITE, POS_W'($urandom), POS_W'($urandom), pick_cell_value());
            else if (sel < 14)
                send_request(OP_READ, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
            else if (sel < 19)
                send_request(OP_FILL, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
            else
                send_request(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
            sent = 1;
        end
    endtask

    task automatic test_register_reset;
        check_register(CFG_FILL_COLOUR, FILL_COLOUR_RST);
        check_register(CFG_TARGET_COLOUR, TARGET_COLOUR_RST);
        model_fill   = FILL_COLOUR_RST;
        model_target = TARGET_COLOUR_RST;
    endtask

    task automatic test_whole_grid_fill;
        gaps_on = 1'b0;
        for (int i = 0; i < NUM_CELLS; i++)
            send_request(OP_WRITE, POS_W'(i / GRID_COLS_DEF), POS_W'(i % GRID_COLS_DEF), 8'h00);
        send_request(OP_FILL, 4'd0, 4'd0, 8'h00);
        send_request(OP_READ, 4'd15, 4'd15, 8'h00);
        send_request(OP_READ, 4'd0, 4'd15, 8'hFF);
    endtask

    task automatic test_directed_cases;
        gaps_on = 1'b1;
        set_colours(8'hFF, 8'h05);
        send_request(OP_FILL, 4'd15, 4'd15, 8'h00);
        send_request(OP_WRITE, 4'd0, 4'd0, 8'h00);
        send_request(OP_WRITE, 4'd0, 4'd15, 8'h5A);
        send_request(OP_WRITE, 4'd15, 4'd0, 8'hA5);
        set_colours(8'h80, 8'h00);
        send_request(OP_FILL, 4'd7, 4'd7, 8'h00);
        send_request(OP_READ, 4'd7, 4'd7, 8'h00);
        send_request(OP_FILL, 4'd0, 4'd1, 8'hFF);
        send_request(OP_READ, 4'd0, 4'd0, 8'h00);
        send_request(OP_READ, 4'd0, 4'd15, 8'h00);
        send_request(OP_READ, 4'd15, 4'd0, 8'h00);
        send_request(OP_UNUSED, 4'd15, 4'd15, 8'hFF);
        send_request(OP_WRITE, 4'd3, 4'd4, 8'h00);
        send_request(OP_WRITE, 4'd3, 4'd5, 8'h00);
        send_request(OP_WRITE, 4'd4, 4'd4, 8'h00);
        send_request(OP_FILL, 4'd3, 4'd4, 8'h00);
        send_request(OP_READ, 4'd4, 4'd4, 8'h00);
    endtask

    task automatic test_equal_colours;
        set_colours(8'h42, 8'h42);
        send_request(OP_WRITE, 4'd2, 4'd2, 8'h42);
        send_request(OP_FILL, 4'd2, 4'd2, 8'h00);
        send_request(OP_READ, 4'd2, 4'd2, 8'h00);
        send_request(OP_FILL, 4'd9, 4'd9, 8'hFF);
    endtask

    task automatic test_random_rounds;
        logic [VAL_W-1:0] fc;
        logic [VAL_W-1:0] tc;
        int done;
        int sent;
        bit drained;
        for (int r = 0; r < 6; r++) begin
            fc = VAL_W'($urandom);
            tc = VAL_W'($urandom);
            if (tc == fc) tc = ~fc;
            case (r)
                0: begin fc = 8'hFF; tc = 8'h00; end
                1: begin fc = 8'h00; tc = 8'hFF; end
                3: tc = fc;
                4: tc = 8'h00;
                default: ;
            endcase
            if (r == 4 && fc == tc) fc = 8'h01;
            set_colours(fc, tc);
            gaps_on = (r != 2);
            done = 0;
            drained = 1'b0;
            while (done < ROUND_ITEMS) begin
                if (!drained && done >= ROUND_ITEMS / 2) begin
                    wait_all_results();
                    drained = 1'b1;
                end
                send_random_step(sent);
                done += sent;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_grid_result want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
                    error_count++;
                end
                if (rsp_painted_count !== want.painted_count) begin
                    $error("painted_count: expected %0d, got %0d",
                           want.painted_count, rsp_painted_count);
                    error_count++;
                end
                if (rsp_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_status);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick == 8'd0)
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                           : (16'($urandom) | 16'($urandom) | 16'h0001);
        out_ready <= stall_pattern[stall_tick[3:0]];
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no handshake for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        req_op        = OP_WRITE;
        req_row       = '0;
        req_col       = '0;
        req_value     = '0;
        out_ready     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        stall_pattern = 16'hFFFF;
        stall_tick    = 8'd1;
        error_count   = 0;
        quiet_cycles  = 0;
        burst_left    = 0;
        gaps_on       = 1'b0;
        n_writes      = 0;
        n_reads       = 0;
        n_fills       = 0;
        n_refused     = 0;
        n_unused      = 0;
        n_settings    = 0;
        max_painted   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_whole_grid_fill();
        test_directed_cases();
        test_equal_colours();
        test_random_rounds();
        wait_all_results();

        $display("Covered %0d writes, %0d reads, %0d unused ops and %0d fills (%0d refused).",
                 n_writes, n_reads, n_unused, n_fills, n_refused);
        $display("Largest fill painted %0d cells across %0d colour settings.",
                 max_painted, n_settings);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
